// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh - concurrent assertion shorthands
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/bsbm_pkg.sv
// ----------------------------------------------------------------------------
// bsbm_pkg - shared types and codes
// Command codes, register indexes and the limb ALU flag bundle.
// ----------------------------------------------------------------------------
package bsbm_pkg;

    // input command codes
    localparam logic CMD_LOAD = 1'b0;   // modulus limb load
    localparam logic CMD_FEED = 1'b1;   // dividend limb

    // register index (paddr word bit)
    localparam logic REG_IDX_LIMBS = 1'b0;

    localparam int CFG_LIMBS_W = 6;
    localparam int IDX_FIELD_W = 5;

    // status from the limb ALU
    typedef struct packed {
        logic top_bit;  // bit shifted out of the limb
        logic borrow;   // borrow out of the subtract
    } alu_flags_t;

endpackage

// File: design/bsbm_ram.sv
// ----------------------------------------------------------------------------
// bsbm_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsbm_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: design/bsbm_step_alu.sv
// ----------------------------------------------------------------------------
// bsbm_step_alu - one limb of a restoring step
// Shifts a limb left with a carried-in bit, subtracts the modulus limb
// with borrow. Both the shifted and the subtracted limb come out.
// ----------------------------------------------------------------------------
module bsbm_step_alu
    import bsbm_pkg::*;
#(
    parameter int LIMB_BITS = 64
) (
    input  logic [LIMB_BITS-1:0] cur_limb,
    input  logic [LIMB_BITS-1:0] mod_limb,
    input  logic                 shift_in,
    input  logic                 borrow_in,
    output logic [LIMB_BITS-1:0] shifted,
    output logic [LIMB_BITS-1:0] diff,
    output alu_flags_t           flags
);

    logic [LIMB_BITS:0] sub_full;

    assign shifted  = {cur_limb[LIMB_BITS-2:0], shift_in};
    assign sub_full = {1'b0, shifted} - {1'b0, mod_limb} - {{LIMB_BITS{1'b0}}, borrow_in};
    assign diff     = sub_full[LIMB_BITS-1:0];

    assign flags.top_bit = cur_limb[LIMB_BITS-1];
    assign flags.borrow  = sub_full[LIMB_BITS];

endmodule

// File: design/bit_serial_bignum_modulo_top.sv
// ----------------------------------------------------------------------------
// bit_serial_bignum_modulo_top - constant-time multi-limb remainder
// Bit-serial restoring reduction V mod U over limbs kept in RAM.
// ----------------------------------------------------------------------------
// Usage: set modulus_limbs (n, 0 acts as 1, above MAX_LIMBS acts as
// MAX_LIMBS) over APB, load the n modulus limbs with cmd=0 (one beat per
// limb, busy stays low), then feed dividend limbs with cmd=1, most
// significant first, dividend_last on the final one. A dividend beat keeps
// busy high while each of its bits runs one restoring step that walks the
// remainder limb by limb through one shared shift/subtract unit: the limb
// reads, then a closing state, since the next step's first limb must see
// the last write of this one. Timing depends only on n, never on data.
// After the final dividend limb the n remainder limbs leave back to back,
// least significant first, each flagged by result_strobe for exactly one
// cycle; the receiver cannot stall, so it must take every beat as it comes.
// The remainder is then cleared, as it is on reset and on any write of
// modulus_limbs. A zero modulus gives V mod 2^(LIMB_BITS*n). Modulus limbs
// never written read back as garbage. Config writes are only legal while
// busy is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bit_serial_bignum_modulo_top
    import bsbm_pkg::*;
#(
    parameter int MAX_LIMBS = 32,
    parameter int LIMB_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [4:0]  limb_index,
    input  logic [63:0] limb_value,
    input  logic        dividend_last,
    // result channel
    output logic        result_strobe,
    output logic [63:0] remainder_limb,
    output logic [4:0]  remainder_index,
    output logic        remainder_last,
    // APB config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;  // limb address
    localparam int CW = $clog2(MAX_LIMBS + 1);                    // holds n itself
    localparam int BW = $clog2(LIMB_BITS);                        // bit counter

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_EMIT
    } state_t;

    state_t                   state_reg;
    logic [CFG_LIMBS_W-1:0]   modulus_limbs_reg;
    logic [CW-1:0]            n_eff;
    logic [CW-1:0]            step_cnt_reg;
    logic [BW-1:0]            bit_cnt_reg;
    logic                     last_reg;
    logic                     sel_reg;       // 1: diff bank holds the remainder
    logic                     rem_zero_reg;  // remainder reads as all zero
    logic                     p_vld_reg;     // limb read data valid
    logic [AW-1:0]            p_idx_reg;

    // payload registers
    logic [LIMB_BITS-1:0]     dividend_reg;
    logic                     cin_reg;
    logic                     borrow_reg;
    logic [63:0]              out_limb_reg;
    logic [IDX_FIELD_W-1:0]   out_idx_reg;
    logic                     out_last_reg;
    logic                     strobe_reg;

    logic                     cfg_wr;
    logic                     accept;
    logic                     load_ok;
    logic [31:0]              idx_wide;
    logic                     rd_issue;
    logic                     step_end;
    logic [AW-1:0]            rd_addr;

    logic [LIMB_BITS-1:0]     bank0_q;
    logic [LIMB_BITS-1:0]     bank1_q;
    logic [LIMB_BITS-1:0]     mod_q;
    logic [LIMB_BITS-1:0]     rem_cur;
    logic [LIMB_BITS-1:0]     alu_shifted;
    logic [LIMB_BITS-1:0]     alu_diff;
    logic                     alu_shift_in;
    logic                     alu_borrow_in;
    alu_flags_t               alu_flags;
    logic                     bank_we;
    logic                     fix;

    // ------------------------------------------------------------------
    // config port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_LIMBS);
    assign prdata = (paddr[2] == REG_IDX_LIMBS) ? 32'(modulus_limbs_reg) : 32'd0;

    // effective limb count, clamped to 1..MAX_LIMBS
    always_comb
    begin
        if (modulus_limbs_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(modulus_limbs_reg) > MAX_LIMBS)
        begin
            n_eff = CW'(MAX_LIMBS);
        end
        else
        begin
            n_eff = CW'(modulus_limbs_reg);
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign idx_wide = 32'(limb_index);
    assign load_ok  = accept && (cmd == CMD_LOAD) && (idx_wide < MAX_LIMBS);
    assign rd_issue = busy && (step_cnt_reg < n_eff);
    assign step_end = busy && (step_cnt_reg == n_eff);
    assign rd_addr  = step_cnt_reg[AW-1:0];

    assign fix = alu_flags.top_bit ^ alu_flags.borrow;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            modulus_limbs_reg <= CFG_LIMBS_W'(1);
            step_cnt_reg      <= '0;
            bit_cnt_reg       <= '0;
            last_reg          <= 1'b0;
            sel_reg           <= 1'b0;
            rem_zero_reg      <= 1'b1;
            p_vld_reg         <= 1'b0;
            p_idx_reg         <= '0;
            strobe_reg        <= 1'b0;
        end
        else
        begin
            p_vld_reg  <= rd_issue;
            p_idx_reg  <= rd_addr;
            strobe_reg <= p_vld_reg && (state_reg == ST_EMIT);

            if (cfg_wr)
            begin
                modulus_limbs_reg <= pwdata[CFG_LIMBS_W-1:0];
                rem_zero_reg      <= 1'b1;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (cmd == CMD_FEED))
                    begin
                        state_reg    <= ST_STEP;
                        step_cnt_reg <= '0;
                        bit_cnt_reg  <= BW'(LIMB_BITS - 1);
                        last_reg     <= dividend_last;
                    end
                end
                ST_STEP:
                begin
                    if (step_end)
                    begin
                        step_cnt_reg <= '0;
                        sel_reg      <= ~fix;
                        rem_zero_reg <= 1'b0;
                        bit_cnt_reg  <= bit_cnt_reg - BW'(1);
                        if (bit_cnt_reg == '0)
                        begin
                            state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                        end
                    end
                    else
                    begin
                        step_cnt_reg <= step_cnt_reg + CW'(1);
                    end
                end
                ST_EMIT:
                begin
                    if (step_end)
                    begin
                        step_cnt_reg <= '0;
                        rem_zero_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                    else
                    begin
                        step_cnt_reg <= step_cnt_reg + CW'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    assign rem_cur       = rem_zero_reg ? '0 : (sel_reg ? bank1_q : bank0_q);
    assign alu_shift_in  = (p_idx_reg == '0) ? dividend_reg[LIMB_BITS-1] : cin_reg;
    assign alu_borrow_in = (p_idx_reg == '0) ? 1'b0 : borrow_reg;
    assign bank_we       = p_vld_reg && (state_reg == ST_STEP);

    always_ff @(posedge clk)
    begin
        if (accept && (cmd == CMD_FEED))
        begin
            dividend_reg <= limb_value[LIMB_BITS-1:0];
        end
        else if ((state_reg == ST_STEP) && step_end)
        begin
            dividend_reg <= {dividend_reg[LIMB_BITS-2:0], 1'b0};
        end

        if (bank_we)
        begin
            cin_reg    <= alu_flags.top_bit;
            borrow_reg <= alu_flags.borrow;
        end

        if (p_vld_reg && (state_reg == ST_EMIT))
        begin
            out_limb_reg <= 64'(rem_cur);
            out_idx_reg  <= IDX_FIELD_W'(p_idx_reg);
            out_last_reg <= step_end;
        end
    end

    bsbm_step_alu #(
        .LIMB_BITS (LIMB_BITS)
    ) u_alu (
        .cur_limb  (rem_cur),
        .mod_limb  (mod_q),
        .shift_in  (alu_shift_in),
        .borrow_in (alu_borrow_in),
        .shifted   (alu_shifted),
        .diff      (alu_diff),
        .flags     (alu_flags)
    );

    // modulus limbs, written by load beats
    bsbm_ram #(
        .WIDTH (LIMB_BITS),
        .DEPTH (MAX_LIMBS)
    ) u_mod_ram (
        .clk     (clk),
        .wr_en   (load_ok),
        .wr_addr (idx_wide[AW-1:0]),
        .wr_data (limb_value[LIMB_BITS-1:0]),
        .rd_addr (rd_addr),
        .rd_data (mod_q)
    );

    // bank 0: shifted remainder, kept when the add-back fires
    bsbm_ram #(
        .WIDTH (LIMB_BITS),
        .DEPTH (MAX_LIMBS)
    ) u_bank0 (
        .clk     (clk),
        .wr_en   (bank_we),
        .wr_addr (p_idx_reg),
        .wr_data (alu_shifted),
        .rd_addr (rd_addr),
        .rd_data (bank0_q)
    );

    // bank 1: shifted minus modulus
    bsbm_ram #(
        .WIDTH (LIMB_BITS),
        .DEPTH (MAX_LIMBS)
    ) u_bank1 (
        .clk     (clk),
        .wr_en   (bank_we),
        .wr_addr (p_idx_reg),
        .wr_data (alu_diff),
        .rd_addr (rd_addr),
        .rd_data (bank1_q)
    );

    assign result_strobe   = strobe_reg;
    assign remainder_limb  = out_limb_reg;
    assign remainder_index = out_idx_reg;
    assign remainder_last  = out_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_last_ends_busy, result_strobe && remainder_last, !busy)
    `ASSERT_IMPL(a_beats_contiguous, result_strobe && (remainder_index != '0), $past(result_strobe))
    `ASSERT_NEXT(a_feed_sets_busy, start && !busy && (cmd == CMD_FEED), busy)
    `ASSERT_IMPL(a_limb_in_range, p_vld_reg, 32'(p_idx_reg) < 32'(n_eff))

endmodule

// File: tb/sv/bit_serial_bignum_modulo_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bit_serial_bignum_modulo_top_test - remainder check for the bignum reducer
// Loads modulus limbs and feeds dividend limbs through the command channel.
// The limb count is reprogrammed over APB between phases. A scoreboard runs
// its own bit-serial restoring reduction and matches every remainder beat in
// order. Directed cases come first: extreme limbs, a zero modulus, limb counts
// that clamp, the unused address, a modulus change mid-dividend and a
// reduction dropped by a limb count write. Random phases follow.
// ----------------------------------------------------------------------------
module bit_serial_bignum_modulo_top_test
    import bsbm_pkg::*;
();

    localparam int MAX_LIMB_SLOTS = 32;
    localparam int BITS_PER_LIMB = 64;
    localparam int ITEM_TARGET = 260;
    localparam int STALL_LIMIT = 20000;   // far above the longest quiet spell

    // word address of the limb count register, and the unused word next to it
    localparam logic [2:0] ADDR_LIMBS = {REG_IDX_LIMBS, 2'b00};
    localparam logic [2:0] ADDR_SPARE = {~REG_IDX_LIMBS, 2'b00};

    typedef struct {
        bit [63:0] limb;
        bit [4:0]  index;
        bit        last;
    } rem_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the modulus, the running remainder and the
    // limb count; expected remainder beats wait in order of arrival.
    // ------------------------------------------------------------------------
    class modred_checker;
        bit [63:0] modulus_limb [MAX_LIMB_SLOTS];
        bit [63:0] partial_rem [MAX_LIMB_SLOTS];
        bit [5:0]  limb_count;
        rem_beat_t pending_limbs [$];
        int        errors;
        int        beats_checked;

        function new();
            foreach (modulus_limb[k])
            begin
                modulus_limb[k] = '0;
                partial_rem[k] = '0;
            end
            limb_count = 6'd1;
            errors = 0;
            beats_checked = 0;
        endfunction

        function int active_count();
            if (limb_count == 0)
                return 1;
            if (limb_count > MAX_LIMB_SLOTS)
                return MAX_LIMB_SLOTS;
            return int'(limb_count);
        endfunction

        function int outstanding();
            return pending_limbs.size();
        endfunction

        function void write_limb_count(bit [5:0] value);
            limb_count = value;
            foreach (partial_rem[k])
                partial_rem[k] = '0;
        endfunction

        // shift one dividend bit in, subtract, add back on (out ^ borrow)
        function void restoring_step(int n, bit din);
            bit        carry;
            bit        shifted_out;
            bit        borrow;
            bit [63:0] r;
            bit [64:0] wide;
            carry = din;
            for (int k = 0; k < n; k++)
            begin
                r = partial_rem[k];
                partial_rem[k] = {r[62:0], carry};
                carry = r[63];
            end
            shifted_out = carry;
            borrow = 1'b0;
            for (int k = 0; k < n; k++)
            begin
                wide = {1'b0, partial_rem[k]} - {1'b0, modulus_limb[k]} - 65'(borrow);
                partial_rem[k] = wide[63:0];
                borrow = wide[64];
            end
            if (shifted_out ^ borrow)
            begin
                carry = 1'b0;
                for (int k = 0; k < n; k++)
                begin
                    wide = {1'b0, partial_rem[k]} + {1'b0, modulus_limb[k]} + 65'(carry);
                    partial_rem[k] = wide[63:0];
                    carry = wide[64];
                end
            end
        endfunction

        function void note_beat(logic c, logic [4:0] idx, logic [63:0] val, logic last);
            int        n;
            rem_beat_t e;
            if (c == CMD_LOAD)
            begin
                modulus_limb[idx] = val;
                return;
            end
            n = active_count();
            for (int b = BITS_PER_LIMB - 1; b >= 0; b--)
                restoring_step(n, val[b]);
            if (!last)
                return;
            for (int k = 0; k < n; k++)
            begin
                e.limb = partial_rem[k];
                e.index = 5'(k);
                e.last = (k == n - 1);
                pending_limbs.push_back(e);
                partial_rem[k] = '0;
            end
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_limb(logic [63:0] limb, logic [4:0] idx, logic last);
            rem_beat_t e;
            beats_checked++;
            if (pending_limbs.size() == 0)
            begin
                report($sformatf("beat %0d unexpected, limb %h index %0d",
                                 beats_checked, limb, idx));
                return;
            end
            e = pending_limbs.pop_front();
            if (limb !== e.limb)
                report($sformatf("beat %0d remainder_limb %h, want %h",
                                 beats_checked, limb, e.limb));
            if (idx !== e.index)
                report($sformatf("beat %0d remainder_index %0d, want %0d",
                                 beats_checked, idx, e.index));
            if (last !== e.last)
                report($sformatf("beat %0d remainder_last %b, want %b",
                                 beats_checked, last, e.last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [4:0]  limb_index;
    logic [63:0] limb_value;
    logic        dividend_last;
    logic        result_strobe;
    logic [63:0] remainder_limb;
    logic [4:0]  remainder_index;
    logic        remainder_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bit_serial_bignum_modulo_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .limb_index      (limb_index),
        .limb_value      (limb_value),
        .dividend_last   (dividend_last),
        .result_strobe   (result_strobe),
        .remainder_limb  (remainder_limb),
        .remainder_index (remainder_index),
        .remainder_last  (remainder_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    modred_checker sb;
    bit [31:0]     loaded;        // modulus slots written at least once
    bit            no_gaps;       // back-to-back beats for this phase
    int            beats_sent;
    int            quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // every remainder beat is taken on the edge that ends its strobe cycle
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            sb.check_limb(remainder_limb, remainder_index, remainder_last);
    end

    // watchdog: any accepted beat, result or register write counts as progress
    always @(posedge clk)
    begin
        if ((start && !busy) || result_strobe || (psel && penable && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Command channel driving
    // ------------------------------------------------------------------------

    // start stays high from one beat into the next when there is no gap;
    // anything else that lets time pass must call hold_off first
    task automatic send_beat(logic c, logic [4:0] idx, logic [63:0] val, logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        limb_index <= idx;
        limb_value <= val;
        dividend_last <= last;
        do
            @(posedge clk);
        while (busy);
        sb.note_beat(c, idx, val, last);
        beats_sent++;
    endtask

    task automatic load_limb(int idx, logic [63:0] val);
        send_beat(CMD_LOAD, 5'(idx), val, 1'($urandom_range(0, 1)));
        loaded[idx] = 1'b1;
    endtask

    // limb_index is don't-care on a dividend beat, so it gets noise
    task automatic feed_limb(logic [63:0] val, logic last);
        send_beat(CMD_FEED, 5'($urandom_range(0, 31)), val, last);
    endtask

    task automatic hold_off();
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // outlasts the busy time of one dividend limb with no output
    task automatic settle();
        repeat (BITS_PER_LIMB * (sb.active_count() + 1) + sb.active_count() + 8)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // APB: setup cycle, then access; only ever issued with the block idle
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        hold_off();
        drain();
        settle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr[2] == REG_IDX_LIMBS)
            sb.write_limb_count(data[5:0]);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // upper data bits are noise; only the low six hold the count
    task automatic set_limbs(bit [5:0] count);
        bit [31:0] w;
        w = $urandom;
        w[5:0] = count;
        write_reg(ADDR_LIMBS, w);
    endtask

    function automatic bit [63:0] rand_limb();
        bit [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = 64'd1 << $urandom_range(0, 63);
            3: v = v >> $urandom_range(1, 63);
            4: v[63] = 1'b1;
            default: ;
        endcase
        return v;
    endfunction

    // pick the next limb count: mostly small, a few clamped or full width
    function automatic bit [5:0] pick_count(int phase, ref int wide_phases);
        int r;
        if (phase == 0)
            return 6'd63;
        if (phase == 1)
            return 6'd32;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 6'd0;
        if (r == 1)
            return 6'd1;
        if (r == 2 && wide_phases < 1)
        begin
            wide_phases++;
            return 6'($urandom_range(33, 63));
        end
        if (r < 9)
            return 6'($urandom_range(1, 3));
        if (r < 14)
            return 6'($urandom_range(4, 8));
        return 6'($urandom_range(9, 16));
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int       phase;
        int       wide_phases;
        int       n;
        int       runs;
        int       len;
        bit       zero_mod;
        bit [5:0] count;

        sb = new();
        loaded = '0;
        no_gaps = 1'b0;
        beats_sent = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_LOAD;
        limb_index = '0;
        limb_value = '0;
        dividend_last = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one limb straight out of reset, largest modulus and dividend
        load_limb(0, '1);
        feed_limb('1, 1'b1);

        // zero modulus: the remainder is just the low limb of the dividend
        load_limb(0, '0);
        feed_limb(64'h8000_0000_0000_0000, 1'b0);
        feed_limb('1, 1'b1);

        // count of zero acts as one; the unused address must not disturb it
        set_limbs(6'd0);
        write_reg(ADDR_SPARE, $urandom);
        load_limb(0, 64'd7);
        feed_limb(rand_limb(), 1'b1);

        // two limbs, top modulus bit set, low limb swapped between dividend
        // limbs - the remainder can end up at or above the new modulus
        set_limbs(6'd2);
        load_limb(1, 64'h8000_0000_0000_0000);
        load_limb(0, 64'd1);
        feed_limb('1, 1'b0);
        load_limb(0, 64'd3);
        feed_limb('1, 1'b1);

        // rewriting the count throws away a half-done reduction
        feed_limb(rand_limb(), 1'b0);
        set_limbs(6'd2);
        feed_limb(rand_limb(), 1'b1);

        // random phases: new count, refresh the modulus, a few reductions
        phase = 0;
        wide_phases = 0;
        while (beats_sent < ITEM_TARGET)
        begin
            count = pick_count(phase, wide_phases);
            set_limbs(count);
            n = sb.active_count();
            no_gaps = ($urandom_range(0, 3) == 0);

            // every slot below n must hold a written limb before dividing
            zero_mod = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < n; i++)
            begin
                if (!loaded[i] || zero_mod || $urandom_range(0, 1))
                    load_limb(i, zero_mod ? 64'd0 : rand_limb());
            end

            runs = (n > 8) ? $urandom_range(1, 2) : $urandom_range(2, 5);
            for (int r = 0; r < runs; r++)
            begin
                len = (n > 8) ? $urandom_range(1, 2) : $urandom_range(1, 5);
                for (int j = 0; j < len; j++)
                begin
                    // occasional modulus rewrite between dividend limbs
                    if (j > 0 && $urandom_range(0, 7) == 0)
                        load_limb($urandom_range(0, MAX_LIMB_SLOTS - 1), rand_limb());
                    feed_limb(rand_limb(), j == len - 1);
                end
                // sometimes let every remainder beat out before moving on
                if ($urandom_range(0, 2) == 0)
                begin
                    hold_off();
                    drain();
                end
            end

            // dangling dividend limb, dropped by the next count write
            if ($urandom_range(0, 3) == 0)
                feed_limb(rand_limb(), 1'b0);
            phase++;
        end

        hold_off();
        drain();
        settle();
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/bsbm_pkg.sv
design/bsbm_ram.sv
design/bsbm_step_alu.sv
design/bit_serial_bignum_modulo_top.sv
tb/sv/bit_serial_bignum_modulo_top_test.sv
